// File: rtl/dns_qname_encoder_assert.svh
// Assertion macros for the DNS question name encoder.
`ifndef DNS_QNAME_ENCODER_ASSERT_SVH
`define DNS_QNAME_ENCODER_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define DQE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DQE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dqe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DQE package
// Shared constants, byte select codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package dqe_pkg;

   localparam int LABEL_MAX_DEFAULT = 32;
   localparam int BYTE_W            = 8;
   localparam int WORD_W            = 16;
   localparam int CSR_IDX_W         = 1;

   localparam logic [BYTE_W-1:0]    DOT_CHAR        = 8'h2E;
   localparam logic [WORD_W-1:0]    QUERY_RESET     = 16'h0001;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_TYPE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_CLASS = 1'b1;

   typedef enum logic [2:0] {
      SEL_LEN,
      SEL_DATA,
      SEL_ZERO,
      SEL_TYPE_HI,
      SEL_TYPE_LO,
      SEL_CLASS_HI,
      SEL_CLASS_LO
   } sel_type;

   typedef struct packed {
      logic    buffer;
      logic    clear_label;
      logic    rd_first;
      logic    rd_next;
      logic    emit;
      sel_type sel;
      logic    run_last;
      logic    done;
   } cmd_type;

   typedef struct packed {
      logic is_dot;
      logic out_free;
      logic label_empty;
      logic data_last;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/dqe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DQE generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module dqe_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/dqe_ctrl.sv
`default_nettype none
`include "dns_qname_encoder_assert.svh"
// ----------------------------------------------------------------------------
// DQE controller
// Sequences buffering, label flush and the trailer bytes of one name.
// ----------------------------------------------------------------------------
module dqe_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last_byte,
   output      logic             req_stall,
   input  wire dqe_pkg::sts_type sts,
   output      dqe_pkg::cmd_type cmd
);
   import dqe_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEN,
      S_DATA,
      S_TERM,
      S_TYPE_HI,
      S_TYPE_LO,
      S_CLASS_HI,
      S_CLASS_LO
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.sel  = SEL_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.buffer = !sts.is_dot;
               last_in    = req_last_byte;
               if (sts.is_dot || req_last_byte) begin
                  state_in = S_LEN;
               end
            end
         end
         S_LEN: begin
            cmd.emit     = 1'b1;
            cmd.sel      = SEL_LEN;
            cmd.rd_first = 1'b1;
            cmd.run_last = !last_ff && sts.label_empty;
            if (sts.out_free) begin
               if (sts.label_empty) begin
                  cmd.clear_label = 1'b1;
                  state_in        = last_ff ? S_TERM : S_IDLE;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            cmd.emit     = 1'b1;
            cmd.sel      = SEL_DATA;
            cmd.run_last = !last_ff && sts.data_last;
            if (sts.out_free) begin
               cmd.rd_next = 1'b1;
               if (sts.data_last) begin
                  cmd.clear_label = 1'b1;
                  state_in        = last_ff ? S_TERM : S_IDLE;
               end
            end
         end
         S_TERM: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_ZERO;
            if (sts.out_free) state_in = S_TYPE_HI;
         end
         S_TYPE_HI: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TYPE_HI;
            if (sts.out_free) state_in = S_TYPE_LO;
         end
         S_TYPE_LO: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TYPE_LO;
            if (sts.out_free) state_in = S_CLASS_HI;
         end
         S_CLASS_HI: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_CLASS_HI;
            if (sts.out_free) state_in = S_CLASS_LO;
         end
         S_CLASS_LO: begin
            cmd.emit     = 1'b1;
            cmd.sel      = SEL_CLASS_LO;
            cmd.run_last = 1'b1;
            cmd.done     = 1'b1;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `DQE_ASSERT(a_done_is_run_last, clock, reset, cmd.done |-> cmd.run_last, "done without run_last")
   `DQE_ASSERT(a_hold_on_stall, clock, reset, (cmd.emit && !sts.out_free) |=> (state_ff == $past(state_ff)), "state advanced while output full")
   `DQE_ASSERT(a_idle_after_class, clock, reset, (state_ff == S_CLASS_LO && sts.out_free) |=> (state_ff == S_IDLE), "no return to idle after class byte")

endmodule
`default_nettype wire

// File: rtl/dqe_datapath.sv
`default_nettype none
`include "dns_qname_encoder_assert.svh"
// ----------------------------------------------------------------------------
// DQE datapath
// Label buffer, fill and overflow tracking, query registers and output byte.
// ----------------------------------------------------------------------------
module dqe_datapath #(
   parameter int LABEL_MAX = dqe_pkg::LABEL_MAX_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [dqe_pkg::BYTE_W-1:0]      req_name_byte,
   input  wire logic                            csr_valid,
   input  wire logic [dqe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dqe_pkg::WORD_W-1:0]      csr_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [dqe_pkg::BYTE_W-1:0]      rsp_out_byte,
   output      logic                            rsp_run_last,
   output      logic                            rsp_query_done,
   output      logic                            rsp_label_too_long,
   input  wire dqe_pkg::cmd_type                cmd,
   output      dqe_pkg::sts_type                sts
);
   import dqe_pkg::*;

   localparam int FW = $clog2(LABEL_MAX + 1);
   localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   logic [FW-1:0]     fill_ff;
   logic              ovf_ff;
   logic [FW-1:0]     idx_ff;
   logic [FW-1:0]     idx_next;
   logic [WORD_W-1:0] qtype_ff;
   logic [WORD_W-1:0] qclass_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              run_last_ff;
   logic              done_ff;
   logic              too_long_ff;
   logic [BYTE_W-1:0] out_byte_in;
   logic [BYTE_W-1:0] rd_data;
   logic              room;
   logic              wr_en;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              load;

   assign room     = (fill_ff < FW'(LABEL_MAX));
   assign wr_en    = cmd.buffer && room;
   assign idx_next = idx_ff + FW'(1);

   assign sts.is_dot      = (req_name_byte == DOT_CHAR);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.label_empty = (fill_ff == '0);
   assign sts.data_last   = (idx_next == fill_ff);

   assign rd_en   = cmd.rd_first || (cmd.rd_next && !sts.data_last);
   assign rd_addr = cmd.rd_first ? '0 : idx_next[AW-1:0];
   assign load    = cmd.emit && sts.out_free;

   dqe_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LABEL_MAX),
      .ADDR_W(AW)
   ) u_label_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[AW-1:0]),
      .wr_data(req_name_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      case (cmd.sel)
         SEL_LEN:      out_byte_in = BYTE_W'(fill_ff);
         SEL_DATA:     out_byte_in = rd_data;
         SEL_TYPE_HI:  out_byte_in = qtype_ff[WORD_W-1:BYTE_W];
         SEL_TYPE_LO:  out_byte_in = qtype_ff[BYTE_W-1:0];
         SEL_CLASS_HI: out_byte_in = qclass_ff[WORD_W-1:BYTE_W];
         SEL_CLASS_LO: out_byte_in = qclass_ff[BYTE_W-1:0];
         default:      out_byte_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         qtype_ff     <= QUERY_RESET;
         qclass_ff    <= QUERY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_label) begin
            fill_ff <= '0;
            ovf_ff  <= 1'b0;
         end else if (cmd.buffer) begin
            if (room) fill_ff <= fill_ff + FW'(1);
            else      ovf_ff  <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_QUERY_TYPE:  qtype_ff  <= csr_data;
               REG_QUERY_CLASS: qclass_ff <= csr_data;
               default: ;
            endcase
         end
         if (load)           rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_first) idx_ff <= '0;
      else if (cmd.rd_next) idx_ff <= idx_next;
      if (load) begin
         out_byte_ff <= out_byte_in;
         run_last_ff <= cmd.run_last;
         done_ff     <= cmd.done;
         too_long_ff <= ovf_ff && (cmd.sel inside {SEL_LEN, SEL_DATA});
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_run_last       = run_last_ff;
   assign rsp_query_done     = done_ff;
   assign rsp_label_too_long = too_long_ff;

   `DQE_ASSERT(a_fill_bound, clock, reset, fill_ff <= FW'(LABEL_MAX), "label fill beyond buffer")
   `DQE_ASSERT(a_ovf_full, clock, reset, ovf_ff |-> (fill_ff == FW'(LABEL_MAX)), "overflow with room left")

endmodule
`default_nettype wire

// File: rtl/dns_qname_encoder.sv
// A plain byte is buffered and gives no output byte.
// A dot or last byte starts a flush: the length state loads the label length,
// then one data byte per cycle while rsp_stall is low; the last
// byte adds 5 trailer bytes. Input stalls until the last byte is loaded.
// Input is not stalled while plain bytes are buffered; it stalls during a flush.
// Reset clears state and sets both query registers to 1.
`default_nettype none
// ----------------------------------------------------------------------------
// DNS question name encoder
// Turns a dotted host name into length-prefixed labels plus type and class.
// ----------------------------------------------------------------------------
module dns_qname_encoder #(
   parameter int LABEL_MAX = dqe_pkg::LABEL_MAX_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [dqe_pkg::BYTE_W-1:0]    req_name_byte,
   input  wire logic                          req_last_byte,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [dqe_pkg::BYTE_W-1:0]    rsp_out_byte,
   output      logic                          rsp_run_last,
   output      logic                          rsp_query_done,
   output      logic                          rsp_label_too_long,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [dqe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dqe_pkg::WORD_W-1:0]    csr_data
);
   import dqe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dqe_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_byte(req_last_byte),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   dqe_datapath #(
      .LABEL_MAX(LABEL_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_name_byte     (req_name_byte),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_query_done    (rsp_query_done),
      .rsp_label_too_long(rsp_label_too_long),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
`default_nettype wire
